@@ design/dcc_pkg.sv @@
// Shared types and constants for the dedispersion chirp coefficient pipeline.
// No dependencies.
package dcc_pkg;

   localparam int BIN_W   = 17;
   localparam int DEN_W   = 61;
   localparam int DVD_W   = 128;
   localparam int QUO_W   = 64;
   localparam int AF_W    = 58;
   localparam int ZW      = 24;
   localparam int XW      = 32;
   localparam int CORDIC_STEPS = 16;
   localparam int NUM_SHIFT    = 11;
   localparam logic signed [XW-1:0] CORDIC_X0 = 32'sd652032874;

   localparam logic signed [ZW-1:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
      24'sd2097152, 24'sd1238021, 24'sd654136, 24'sd332050,
      24'sd166669,  24'sd83416,   24'sd41718,  24'sd20860,
      24'sd10430,   24'sd5215,    24'sd2608,   24'sd1304,
      24'sd652,     24'sd326,     24'sd163,    24'sd81
   };

   localparam logic [2:0] REG_CHIRP_SCALE = 3'd0;
   localparam logic [2:0] REG_REF_FREQ    = 3'd1;
   localparam logic [2:0] REG_BIN_SPACING = 3'd2;
   localparam logic [2:0] REG_CENTER_BIN  = 3'd3;
   localparam logic [2:0] REG_LOWER_SB    = 3'd4;
   localparam logic [2:0] REG_FFT_LOG2    = 3'd5;

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             fault;
      logic             flip;
   } tag_type;

endpackage

@@ design/dcc_front.sv @@
// Offset frequency, denominator and squared numerator: five register stages.
// Depends on dcc_pkg.
module dcc_front import dcc_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [BIN_W-1:0]        in_bin,
   input  logic [33:0]             ref_freq,
   input  logic [39:0]             bin_spacing,
   input  logic [17:0]             center_bin,
   input  logic                    lower_sideband,
   output logic                    out_valid,
   output tag_type                 out_tag,
   output logic [DVD_W-1:0]        out_dvd,
   output logic [DEN_W-1:0]        out_den
);

   logic [4:0] vld_ff;
   logic [BIN_W-1:0] bin1_ff, bin2_ff, bin3_ff, bin4_ff;
   logic signed [19:0] d_in;
   logic [17:0] ad_in, ad_ff;
   logic fneg1_ff, fneg2_ff, fneg3_ff;
   logic [37:0] pplo_ff, pphi_ff;
   logic [AF_W-1:0] af_in, af_ff;
   logic signed [DEN_W-1:0] f_in, den_in;
   logic [DEN_W-1:0] aden_in, aden4_ff, aden5_ff;
   logic [63:0] pll_ff;
   logic [57:0] phl_ff;
   logic [51:0] phh_ff;
   logic fault4_ff, flip4_ff;
   logic [115:0] sq_in;
   logic [DVD_W-1:0] dvd_ff;
   tag_type tag_ff;

   always_comb begin
      d_in    = signed'({3'b000, in_bin}) - 20'(signed'(center_bin));
      ad_in   = d_in[19] ? 18'(-d_in) : 18'(d_in);
      af_in   = AF_W'(pplo_ff) + (AF_W'(pphi_ff) << 20);
      f_in    = fneg3_ff ? -signed'(DEN_W'(af_ff)) : signed'(DEN_W'(af_ff));
      den_in  = f_in + signed'(DEN_W'({ref_freq, 16'h0000}));
      aden_in = den_in[DEN_W-1] ? DEN_W'(-den_in) : DEN_W'(den_in);
      sq_in   = 116'(pll_ff) + (116'(phl_ff) << 33) + (116'(phh_ff) << 64);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
      bin1_ff  <= in_bin;
      ad_ff    <= ad_in;
      fneg1_ff <= d_in[19] ^ lower_sideband;
      bin2_ff  <= bin1_ff;
      fneg2_ff <= fneg1_ff;
      pplo_ff  <= bin_spacing[19:0] * ad_ff;
      pphi_ff  <= bin_spacing[39:20] * ad_ff;
      bin3_ff  <= bin2_ff;
      fneg3_ff <= fneg2_ff;
      af_ff    <= af_in;
      bin4_ff  <= bin3_ff;
      aden4_ff <= aden_in;
      fault4_ff <= (den_in == '0);
      flip4_ff <= lower_sideband ^ den_in[DEN_W-1];
      pll_ff   <= af_ff[31:0] * af_ff[31:0];
      phl_ff   <= af_ff[57:32] * af_ff[31:0];
      phh_ff   <= af_ff[57:32] * af_ff[57:32];
      tag_ff   <= '{bin: bin4_ff, fault: fault4_ff, flip: flip4_ff};
      aden5_ff <= aden4_ff;
      dvd_ff   <= DVD_W'(sq_in) << NUM_SHIFT;
   end

   assign out_valid = vld_ff[4];
   assign out_tag   = tag_ff;
   assign out_dvd   = dvd_ff;
   assign out_den   = aden5_ff;

endmodule

@@ design/dcc_div.sv @@
// Restoring divider, one quotient bit per register stage, low 64 quotient bits kept.
// Depends on dcc_pkg.
module dcc_div import dcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tag_type            in_tag,
   input  logic [DVD_W-1:0]   in_dvd,
   input  logic [DEN_W-1:0]   in_den,
   output logic               out_valid,
   output tag_type            out_tag,
   output logic [QUO_W-1:0]   out_quo
);

   logic               vld_ff [0:DVD_W-1];
   tag_type            tag_ff [0:DVD_W-1];
   logic [DVD_W-1:0]   dvd_ff [0:DVD_W-1];
   logic [DEN_W-1:0]   den_ff [0:DVD_W-1];
   logic [DEN_W-1:0]   rem_ff [0:DVD_W-1];
   logic [QUO_W-1:0]   quo_ff [0:DVD_W-1];

   for (genvar i = 0; i < DVD_W; i++) begin : g_stage
      logic             vld_cur;
      tag_type          tag_cur;
      logic [DVD_W-1:0] dvd_cur;
      logic [DEN_W-1:0] den_cur, rem_cur;
      logic [QUO_W-1:0] quo_cur;
      logic [DEN_W:0]   sh_in;
      logic             ge_in;

      if (i == 0) begin : g_first
         assign vld_cur = in_valid;
         assign tag_cur = in_tag;
         assign dvd_cur = in_dvd;
         assign den_cur = in_den;
         assign rem_cur = '0;
         assign quo_cur = '0;
      end else begin : g_next
         assign vld_cur = vld_ff[i-1];
         assign tag_cur = tag_ff[i-1];
         assign dvd_cur = dvd_ff[i-1];
         assign den_cur = den_ff[i-1];
         assign rem_cur = rem_ff[i-1];
         assign quo_cur = quo_ff[i-1];
      end

      assign sh_in = {rem_cur, dvd_cur[DVD_W-1]};
      assign ge_in = (sh_in >= {1'b0, den_cur});

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
         tag_ff[i] <= tag_cur;
         dvd_ff[i] <= dvd_cur << 1;
         den_ff[i] <= den_cur;
         rem_ff[i] <= ge_in ? DEN_W'(sh_in - {1'b0, den_cur}) : DEN_W'(sh_in);
         quo_ff[i] <= {quo_cur[QUO_W-2:0], ge_in};
      end
   end

   assign out_valid = vld_ff[DVD_W-1];
   assign out_tag   = tag_ff[DVD_W-1];
   assign out_quo   = quo_ff[DVD_W-1];

endmodule

@@ design/dcc_phase.sv @@
// Phase product K*Q modulo 2^64 in four partial products, sign and turn fraction.
// Depends on dcc_pkg.
module dcc_phase import dcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tag_type            in_tag,
   input  logic [QUO_W-1:0]   in_quo,
   input  logic [47:0]        chirp_scale,
   output logic               out_valid,
   output logic [BIN_W-1:0]   out_bin,
   output logic               out_fault,
   output logic [23:0]        out_frac
);

   logic [1:0] vld_ff;
   tag_type tag_ff;
   logic [55:0] p00_ff, p10_ff, p01_ff, p11_ff;
   logic [63:0] p_in, ps_in;
   logic [BIN_W-1:0] bin_ff;
   logic fault_ff;
   logic [23:0] frac_ff;

   always_comb begin
      p_in  = 64'(p00_ff) + (64'(p10_ff) << 24) + (64'(p01_ff) << 32) + (64'(p11_ff) << 56);
      ps_in = tag_ff.flip ? (64'd0 - p_in) : p_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[0], in_valid};
      end
      tag_ff   <= in_tag;
      p00_ff   <= chirp_scale[23:0]  * in_quo[31:0];
      p10_ff   <= chirp_scale[47:24] * in_quo[31:0];
      p01_ff   <= chirp_scale[23:0]  * in_quo[63:32];
      p11_ff   <= chirp_scale[47:24] * in_quo[63:32];
      bin_ff   <= tag_ff.bin;
      fault_ff <= tag_ff.fault;
      frac_ff  <= tag_ff.fault ? 24'd0 : ps_in[58:35];
   end

   assign out_valid = vld_ff[1];
   assign out_bin   = bin_ff;
   assign out_fault = fault_ff;
   assign out_frac  = frac_ff;

endmodule

@@ design/dcc_cordic.sv @@
// Rotation CORDIC, one iteration per stage, then quadrant map and 1/N rounding.
// Depends on dcc_pkg.
module dcc_cordic import dcc_pkg::*; #(
   parameter int COEFF_WIDTH  = 16,
   parameter int MAX_FFT_LOG2 = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [BIN_W-1:0]       in_bin,
   input  logic                   in_fault,
   input  logic [23:0]            in_frac,
   input  logic [4:0]             fft_size_log2,
   output logic                   out_valid,
   output logic [COEFF_WIDTH-1:0] out_real,
   output logic [COEFF_WIDTH-1:0] out_imag,
   output logic [BIN_W-1:0]       out_bin,
   output logic                   out_fault
);

   localparam int SH_MAX = 31 - COEFF_WIDTH + MAX_FFT_LOG2;
   localparam int RW     = (SH_MAX > XW ? SH_MAX : XW) + 2;
   localparam int SHW    = $clog2(SH_MAX + 1);

   logic                  vld_ff   [0:CORDIC_STEPS-1];
   logic [BIN_W-1:0]      bin_ff   [0:CORDIC_STEPS-1];
   logic                  fault_ff [0:CORDIC_STEPS-1];
   logic [1:0]            quad_ff  [0:CORDIC_STEPS-1];
   logic signed [XW-1:0]  x_ff     [0:CORDIC_STEPS-1];
   logic signed [XW-1:0]  y_ff     [0:CORDIC_STEPS-1];
   logic signed [ZW-1:0]  z_ff     [0:CORDIC_STEPS-1];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
      logic                 vld_cur, fault_cur;
      logic [BIN_W-1:0]     bin_cur;
      logic [1:0]           quad_cur;
      logic signed [XW-1:0] x_cur, y_cur;
      logic signed [ZW-1:0] z_cur;

      if (i == 0) begin : g_first
         assign vld_cur   = in_valid;
         assign bin_cur   = in_bin;
         assign fault_cur = in_fault;
         assign quad_cur  = in_frac[23:22];
         assign x_cur     = CORDIC_X0;
         assign y_cur     = '0;
         assign z_cur     = signed'({2'b00, in_frac[21:0]});
      end else begin : g_next
         assign vld_cur   = vld_ff[i-1];
         assign bin_cur   = bin_ff[i-1];
         assign fault_cur = fault_ff[i-1];
         assign quad_cur  = quad_ff[i-1];
         assign x_cur     = x_ff[i-1];
         assign y_cur     = y_ff[i-1];
         assign z_cur     = z_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
         bin_ff[i]   <= bin_cur;
         fault_ff[i] <= fault_cur;
         quad_ff[i]  <= quad_cur;
         if (!z_cur[ZW-1]) begin
            x_ff[i] <= x_cur - (y_cur >>> i);
            y_ff[i] <= y_cur + (x_cur >>> i);
            z_ff[i] <= z_cur - ATAN_TURNS[i];
         end else begin
            x_ff[i] <= x_cur + (y_cur >>> i);
            y_ff[i] <= y_cur - (x_cur >>> i);
            z_ff[i] <= z_cur + ATAN_TURNS[i];
         end
      end
   end

   logic                 mvld_ff, rvld_ff;
   logic [BIN_W-1:0]     mbin_ff, rbin_ff;
   logic                 mfault_ff, rfault_ff;
   logic signed [RW-1:0] c_in, ns_in, c_ff, ns_ff;
   logic signed [RW-1:0] xe, ye, half_in;
   logic [4:0]           lg_in;
   logic [SHW-1:0]       sh_in;
   logic [COEFF_WIDTH-1:0] re_ff, im_ff;
   logic signed [RW-1:0] re_in, im_in;

   always_comb begin
      xe = RW'(x_ff[CORDIC_STEPS-1]);
      ye = RW'(y_ff[CORDIC_STEPS-1]);
      case (quad_ff[CORDIC_STEPS-1])
         2'd0: begin c_in = xe;  ns_in = -ye; end
         2'd1: begin c_in = -ye; ns_in = -xe; end
         2'd2: begin c_in = -xe; ns_in = ye;  end
         default: begin c_in = ye; ns_in = xe; end
      endcase
      if (fft_size_log2 < 5'd4) begin
         lg_in = 5'd4;
      end else if (fft_size_log2 > 5'(MAX_FFT_LOG2)) begin
         lg_in = 5'(MAX_FFT_LOG2);
      end else begin
         lg_in = fft_size_log2;
      end
      sh_in   = SHW'(31 - COEFF_WIDTH) + SHW'(lg_in);
      half_in = signed'(RW'(1) << (sh_in - SHW'(1)));
      re_in   = (c_ff + half_in) >>> sh_in;
      im_in   = (ns_ff + half_in) >>> sh_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mvld_ff <= 1'b0;
         rvld_ff <= 1'b0;
      end else begin
         mvld_ff <= vld_ff[CORDIC_STEPS-1];
         rvld_ff <= mvld_ff;
      end
      mbin_ff   <= bin_ff[CORDIC_STEPS-1];
      mfault_ff <= fault_ff[CORDIC_STEPS-1];
      c_ff      <= c_in;
      ns_ff     <= ns_in;
      rbin_ff   <= mbin_ff;
      rfault_ff <= mfault_ff;
      re_ff     <= re_in[COEFF_WIDTH-1:0];
      im_ff     <= im_in[COEFF_WIDTH-1:0];
   end

   assign out_valid = rvld_ff;
   assign out_real  = re_ff;
   assign out_imag  = im_ff;
   assign out_bin   = rbin_ff;
   assign out_fault = rfault_ff;

endmodule

@@ design/dedispersion_chirp_coefficients.sv @@
// Coherent dedispersion chirp coefficient generator, top level with register file.
// Pipeline from start to rsp_valid: front, divider, phase and CORDIC register stages, in that order.
// Throughput one item per cycle, set by the one-bit-per-stage divider pipeline.
// busy stays low; the receiver cannot stall and every result shows for one cycle.
// Synchronous reset clears valid bits and the register file; fft_size_log2 resets to 10.
// Depends on dcc_pkg, dcc_front, dcc_div, dcc_phase, dcc_cordic.
module dedispersion_chirp_coefficients import dcc_pkg::*; #(
   parameter int MAX_FFT_LOG2 = 16,
   parameter int COEFF_WIDTH  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [BIN_W-1:0]       req_bin_index,
   output logic                   rsp_valid,
   output logic [COEFF_WIDTH-1:0] rsp_coeff_real,
   output logic [COEFF_WIDTH-1:0] rsp_coeff_imag,
   output logic [BIN_W-1:0]       rsp_bin_out,
   output logic                   rsp_div_fault,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [47:0]            csr_wdata
);

   logic [47:0] chirp_scale_ff;
   logic [33:0] ref_freq_ff;
   logic [39:0] bin_spacing_ff;
   logic [17:0] center_bin_ff;
   logic        lower_sb_ff;
   logic [4:0]  fft_log2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chirp_scale_ff <= '0;
         ref_freq_ff    <= '0;
         bin_spacing_ff <= '0;
         center_bin_ff  <= '0;
         lower_sb_ff    <= 1'b0;
         fft_log2_ff    <= 5'd10;
      end else if (csr_we) begin
         case (csr_index)
            REG_CHIRP_SCALE: chirp_scale_ff <= csr_wdata;
            REG_REF_FREQ:    ref_freq_ff    <= csr_wdata[33:0];
            REG_BIN_SPACING: bin_spacing_ff <= csr_wdata[39:0];
            REG_CENTER_BIN:  center_bin_ff  <= csr_wdata[17:0];
            REG_LOWER_SB:    lower_sb_ff    <= csr_wdata[0];
            REG_FFT_LOG2:    fft_log2_ff    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic             fr_valid, dv_valid, ph_valid, ph_fault;
   tag_type          fr_tag, dv_tag;
   logic [DVD_W-1:0] fr_dvd;
   logic [DEN_W-1:0] fr_den;
   logic [QUO_W-1:0] dv_quo;
   logic [BIN_W-1:0] ph_bin;
   logic [23:0]      ph_frac;

   dcc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start & ~busy),
      .in_bin         (req_bin_index),
      .ref_freq       (ref_freq_ff),
      .bin_spacing    (bin_spacing_ff),
      .center_bin     (center_bin_ff),
      .lower_sideband (lower_sb_ff),
      .out_valid      (fr_valid),
      .out_tag        (fr_tag),
      .out_dvd        (fr_dvd),
      .out_den        (fr_den)
   );

   dcc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_tag    (fr_tag),
      .in_dvd    (fr_dvd),
      .in_den    (fr_den),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quo   (dv_quo)
   );

   dcc_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_tag      (dv_tag),
      .in_quo      (dv_quo),
      .chirp_scale (chirp_scale_ff),
      .out_valid   (ph_valid),
      .out_bin     (ph_bin),
      .out_fault   (ph_fault),
      .out_frac    (ph_frac)
   );

   dcc_cordic #(
      .COEFF_WIDTH  (COEFF_WIDTH),
      .MAX_FFT_LOG2 (MAX_FFT_LOG2)
   ) u_cordic (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (ph_valid),
      .in_bin        (ph_bin),
      .in_fault      (ph_fault),
      .in_frac       (ph_frac),
      .fft_size_log2 (fft_log2_ff),
      .out_valid     (rsp_valid),
      .out_real      (rsp_coeff_real),
      .out_imag      (rsp_coeff_imag),
      .out_bin       (rsp_bin_out),
      .out_fault     (rsp_div_fault)
   );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for dedispersion_chirp_coefficients: drives bins and registers,
// predicts every coefficient in a scoreboard class and compares each result in order.
// Depends on dcc_pkg and the dedispersion_chirp_coefficients RTL.
module tb;
   import dcc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 16;
   localparam int MAX_LG = 16;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam logic [2:0] REG_UNUSED_LO = 3'd6;
   localparam logic [2:0] REG_UNUSED_HI = 3'd7;

   typedef struct {
      logic [CW-1:0]    real_part;
      logic [CW-1:0]    imag_part;
      logic [BIN_W-1:0] bin;
      logic             fault;
   } coeff_type;

   class chirp_scoreboard;
      logic [47:0]        chirp_scale;
      logic [33:0]        ref_freq;
      logic [39:0]        bin_spacing;
      logic signed [17:0] center_bin;
      logic               lower_sb;
      logic [4:0]         fft_log2;
      coeff_type          pending[$];
      int                 errors;

      function void clear_regs();
         chirp_scale = '0;
         ref_freq = '0;
         bin_spacing = '0;
         center_bin = '0;
         lower_sb = 1'b0;
         fft_log2 = 5'd10;
      endfunction

      function void set_reg(logic [2:0] idx, logic [47:0] val);
         case (idx)
            REG_CHIRP_SCALE: chirp_scale = val[47:0];
            REG_REF_FREQ:    ref_freq = val[33:0];
            REG_BIN_SPACING: bin_spacing = val[39:0];
            REG_CENTER_BIN:  center_bin = val[17:0];
            REG_LOWER_SB:    lower_sb = val[0];
            REG_FFT_LOG2:    fft_log2 = val[4:0];
            default: ;
         endcase
      endfunction

      function void note_bin(logic [BIN_W-1:0] bin);
         longint        f, den, x, y, z, xs, ys, c, s, re, im, half;
         logic [127:0]  num, af, ad;
         logic [63:0]   q, p;
         logic [23:0]   t;
         int            lg, sh;
         coeff_type     e;
         f = longint'(bin_spacing) * (longint'(bin) - longint'(center_bin));
         if (lower_sb) f = -f;
         den = f + (longint'(ref_freq) <<< 16);
         t = '0;
         if (den != 0) begin
            af = (f < 0) ? 128'(-f) : 128'(f);
            ad = (den < 0) ? 128'(-den) : 128'(den);
            num = (af * af) << NUM_SHIFT;
            q = 64'(num / ad);
            p = 64'(chirp_scale) * q;
            if (lower_sb != (den < 0)) p = -p;
            t = p[58:35];
         end
         x = CORDIC_X0;
         y = 0;
         z = longint'(t[21:0]);
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
               x = x - ys; y = y + xs; z = z - ATAN_TURNS[i];
            end else begin
               x = x + ys; y = y - xs; z = z + ATAN_TURNS[i];
            end
         end
         case (t[23:22])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         lg = fft_log2;
         if (lg < 4) lg = 4;
         if (lg > MAX_LG) lg = MAX_LG;
         sh = 31 - CW + lg;
         half = longint'(1) <<< (sh - 1);
         re = (c + half) >>> sh;
         im = (-s + half) >>> sh;
         e.real_part = re[CW-1:0];
         e.imag_part = im[CW-1:0];
         e.bin = bin;
         e.fault = (den == 0);
         pending.push_back(e);
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function void check_coeff(logic [CW-1:0] re, logic [CW-1:0] im,
                                logic [BIN_W-1:0] bin, logic fault);
         coeff_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result for bin %0d", bin));
            return;
         end
         e = pending.pop_front();
         if (re !== e.real_part)
            report($sformatf("bin %0d real %h, want %h", e.bin, re, e.real_part));
         if (im !== e.imag_part)
            report($sformatf("bin %0d imag %h, want %h", e.bin, im, e.imag_part));
         if (bin !== e.bin)
            report($sformatf("bin_out %0d, want %0d", bin, e.bin));
         if (fault !== e.fault)
            report($sformatf("bin %0d fault %b, want %b", e.bin, fault, e.fault));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [BIN_W-1:0]       req_bin_index;
   logic                   rsp_valid;
   logic [CW-1:0]          rsp_coeff_real;
   logic [CW-1:0]          rsp_coeff_imag;
   logic [BIN_W-1:0]       rsp_bin_out;
   logic                   rsp_div_fault;
   logic                   csr_we;
   logic [2:0]             csr_index;
   logic [47:0]            csr_wdata;

   chirp_scoreboard sb;
   int cycles;
   bit allow_idle;

   dedispersion_chirp_coefficients #(.MAX_FFT_LOG2(MAX_LG), .COEFF_WIDTH(CW)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_bin_index(req_bin_index), .rsp_valid(rsp_valid),
      .rsp_coeff_real(rsp_coeff_real), .rsp_coeff_imag(rsp_coeff_imag),
      .rsp_bin_out(rsp_bin_out), .rsp_div_fault(rsp_div_fault),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
      if (!reset) begin
         if (start && !busy) sb.note_bin(req_bin_index);
         if (rsp_valid) sb.check_coeff(rsp_coeff_real, rsp_coeff_imag, rsp_bin_out,
                                       rsp_div_fault);
      end
   end

   task automatic send_bin(logic [BIN_W-1:0] bin);
      if (allow_idle && $urandom_range(99) < 12) begin
         start <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_bin_index <= bin;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_regs(logic [47:0] k, logic [47:0] f0, logic [47:0] sp,
                             logic [47:0] cen, logic [47:0] lsb, logic [47:0] lg);
      logic [2:0]  idx[6];
      logic [47:0] val[6];
      idx = '{REG_CHIRP_SCALE, REG_REF_FREQ, REG_BIN_SPACING, REG_CENTER_BIN,
              REG_LOWER_SB, REG_FFT_LOG2};
      val = '{k, f0, sp, cen, lsb, lg};
      for (int i = 0; i < 6; i++) begin
         csr_we <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= val[i];
         sb.set_reg(idx[i], val[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_unused(logic [2:0] idx);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= {$urandom, $urandom};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [47:0] pick(logic [47:0] hi_val, int bits);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(7))
         0: return '0;
         1: return hi_val;
         2: return r[47:0] & ((48'd1 << $urandom_range(bits, 1)) - 1);
         default: return r[47:0] & hi_val;
      endcase
   endfunction

   initial begin
      logic [47:0] lg;
      int          n;
      sb = new();
      sb.clear_regs();
      sb.errors = 0;
      cycles = 0;
      allow_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_bin_index = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset registers: zero offset frequency and zero f0 give a fault
      send_bin(17'd0); send_bin(17'd65536); send_bin(17'h1FFFF); send_bin(17'd1);
      drain();
      write_regs(48'hFFFF_FFFF_FFFF, 48'd5, 48'd65536, 48'd100, 48'd0, 48'd0);
      write_unused(REG_UNUSED_LO);
      write_unused(REG_UNUSED_HI);
      send_bin(17'd95); send_bin(17'd94); send_bin(17'd96); send_bin(17'd0);
      send_bin(17'h1FFFF); send_bin(17'd65536);
      drain();
      write_regs(48'd1, 48'd7, 48'd65536, 48'd10, 48'd1, 48'd16);
      send_bin(17'd17); send_bin(17'd3); send_bin(17'd0); send_bin(17'h1FFFF);
      drain();
      write_regs(48'hFFFF_FFFF_FFFF, 48'h3_FFFF_FFFF, 48'hFF_FFFF_FFFF, 48'h20000,
                 48'd0, 48'd31);
      send_bin(17'd0); send_bin(17'h1FFFF); send_bin(17'd65536); send_bin(17'd1);
      drain();
      write_regs(48'h1234_5678_9ABC, 48'd0, 48'hFF_FFFF_FFFF, 48'h1FFFF, 48'd1, 48'd4);
      send_bin(17'd0); send_bin(17'h1FFFF); send_bin(17'd65536); send_bin(17'd7);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         lg = (ph == 0) ? 48'd16 : 48'($urandom_range(18, 2));
         write_regs(pick(48'hFFFF_FFFF_FFFF, 48), pick(48'h3_FFFF_FFFF, 34),
                    pick(48'hFF_FFFF_FFFF, 40), pick(48'h3FFFF, 18),
                    48'($urandom_range(1)), lg);
         n = 0;
         while (n < 212) begin
            allow_idle = !(ph == 2 && n < 150);
            if ($urandom_range(9) < 7)
               send_bin(17'($urandom_range(32'd1 << sb.fft_log2[4:0] > 32'd65536 ?
                                           65536 : (32'd1 << sb.fft_log2[4:0]))));
            else
               send_bin(17'($urandom));
            n++;
         end
         drain();
      end

      repeat (200) @(posedge clock);
      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending.size()));
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule

@@ sim.f @@
design/dcc_pkg.sv
design/dcc_front.sv
design/dcc_div.sv
design/dcc_phase.sv
design/dcc_cordic.sv
design/dedispersion_chirp_coefficients.sv
tb/tb.sv
